// ===== hdl/wss_pkg.sv =====
// Shared types, constants and the waypoint table of the smoothstep waypoint sequencer.
// No dependencies.
package wss_pkg;

  localparam int CFG_WIDTH     = 8;
  localparam int NUM_JOINTS_DEF = 7;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TICK_WIDTH_DEF = 8;
  localparam int TABLE_JOINTS  = 7;
  localparam int JOINT_IDX_W   = 4;
  localparam int S_W           = 17;
  localparam int MUL_A_W       = 34;
  localparam int MUL_B_W       = 19;
  localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int FRAC_W        = 16;

  localparam logic [CFG_WIDTH-1:0] LONG_TICKS_RESET  = 8'd100;
  localparam logic [CFG_WIDTH-1:0] SHORT_TICKS_RESET = 8'd75;

  localparam logic [S_W-1:0]     S_ONE     = 17'd65536;
  localparam logic [MUL_B_W-1:0] SMOOTH_K3 = 19'd196608;

  typedef enum logic [0:0] {
    REG_LONG_TICKS  = 1'b0,
    REG_SHORT_TICKS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_INIT     = 3'd0,
    PH_READY    = 3'd1,
    PH_APPROACH = 3'd2,
    PH_GRASP    = 3'd3,
    PH_LIFT     = 3'd4,
    PH_MOVE     = 3'd5,
    PH_RELEASE  = 3'd6,
    PH_RETURN   = 3'd7
  } phase_t;

  typedef logic signed [15:0] q14_t;

  localparam q14_t WAYPOINT_ROM [8][TABLE_JOINTS] = '{
    '{16'sd0,     16'sd0,     16'sd0,     16'sd0,    16'sd0, 16'sd229, 16'sd229},
    '{16'sd0,     16'sd0,     16'sd0,     16'sd0,    16'sd0, 16'sd229, 16'sd229},
    '{16'sd0,     16'sd4915,  -16'sd8192, 16'sd3277, 16'sd0, 16'sd229, 16'sd229},
    '{16'sd0,     16'sd4915,  -16'sd8192, 16'sd3277, 16'sd0, 16'sd0,   16'sd0},
    '{16'sd0,     -16'sd3277, -16'sd4915, 16'sd1638, 16'sd0, 16'sd0,   16'sd0},
    '{16'sd25723, -16'sd3277, -16'sd4915, 16'sd1638, 16'sd0, 16'sd0,   16'sd0},
    '{16'sd25723, -16'sd3277, -16'sd4915, 16'sd1638, 16'sd0, 16'sd229, 16'sd229},
    '{16'sd0,     16'sd0,     16'sd0,     16'sd0,    16'sd0, 16'sd229, 16'sd229}
  };

  function automatic q14_t waypoint(phase_t ph, logic [JOINT_IDX_W-1:0] j);
    q14_t v;
    v = '0;
    if (j < JOINT_IDX_W'(TABLE_JOINTS)) begin
      v = WAYPOINT_ROM[ph][j[2:0]];
    end
    return v;
  endfunction

endpackage

// ===== hdl/waypoint_smoothstep_sequencer.sv =====
// Top level of the smoothstep waypoint sequencer: phase sequencer, divider and blend loop.
// Depends on wss_pkg and wss_mul.
//
// Each accepted item yields one result. An item with tick low, or the first tick after
// reset, goes straight to the result state. Any other tick first runs a bit-serial divider
// that forms the phase fraction one bit per cycle (skipped once the phase is complete), then
// one shared multiplier with a registered product forms s squared, the smoothstep weight and
// each joint's blend in turn. The input is stalled from accept until the result is taken.
module waypoint_smoothstep_sequencer import wss_pkg::*; #(
  parameter int NUM_JOINTS  = NUM_JOINTS_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANGLE_WIDTH-1:0] base_angle,
  output logic signed [ANGLE_WIDTH-1:0] shoulder_angle,
  output logic signed [ANGLE_WIDTH-1:0] elbow_angle,
  output logic signed [ANGLE_WIDTH-1:0] wrist_pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0] wrist_roll_angle,
  output logic signed [ANGLE_WIDTH-1:0] gripper_left_pos,
  output logic signed [ANGLE_WIDTH-1:0] gripper_right_pos,
  output logic [2:0]                    phase_out
);

  localparam int AW    = ANGLE_WIDTH;
  localparam int TW    = TICK_WIDTH;
  localparam int JW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int CMP_W = (TW > CFG_WIDTH) ? TW : CFG_WIDTH;
  localparam int OUT_JOINTS = 7;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};
  localparam logic [JW-1:0] LAST_JOINT = JW'(NUM_JOINTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SQR,
    S_CUBE,
    S_WGT,
    S_JMUL,
    S_JACC,
    S_END,
    S_OUT
  } state_t;

  state_t                     state;
  logic [CFG_WIDTH-1:0]       long_ticks;
  logic [CFG_WIDTH-1:0]       short_ticks;
  phase_t                     phase;
  logic [TW-1:0]              elapsed;
  logic [TW-1:0]              dur;
  logic [TW-1:0]              rem;
  logic [S_W-1:0]             s;
  logic [S_W-1:0]             w;
  logic [3:0]                 div_cnt;
  logic [JW-1:0]              jcnt;
  logic signed [AW-1:0]       start_pose   [NUM_JOINTS];
  logic signed [AW-1:0]       current_pose [NUM_JOINTS];

  logic [CFG_WIDTH-1:0]       dur_raw;
  logic [TW-1:0]              dur_next;
  logic [TW-1:0]              elapsed_next;
  logic [TW:0]                rem_sh;
  logic                       rem_ge;
  logic signed [AW-1:0]       tgt;
  logic signed [AW:0]         delta;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;
  logic signed [MUL_P_W-1:0]  rounded;
  logic                       in_acc;
  logic signed [AW-1:0]       out_pose [OUT_JOINTS];

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    dur_raw = (phase == PH_GRASP || phase == PH_RELEASE) ? short_ticks : long_ticks;
    if (dur_raw == '0) begin
      dur_next = TW'(1);
    end else if (CMP_W'(dur_raw) > CMP_W'(TICK_MAX)) begin
      dur_next = TICK_MAX;
    end else begin
      dur_next = TW'(dur_raw);
    end
    elapsed_next = (elapsed != TICK_MAX) ? elapsed + TW'(1) : elapsed;
    rem_sh = {rem, 1'b0};
    rem_ge = (rem_sh >= {1'b0, dur});
    tgt = AW'(waypoint(phase, JOINT_IDX_W'(jcnt)));
    delta = $signed({tgt[AW-1], tgt}) - $signed({start_pose[jcnt][AW-1], start_pose[jcnt]});
    rounded = prod + MUL_P_W'(32768);
  end

  always_comb begin
    case (state)
      S_SQR: begin
        mul_a = $signed(MUL_A_W'(s));
        mul_b = $signed(MUL_B_W'(s));
      end
      S_CUBE: begin
        mul_a = $signed({1'b0, prod[32:0]});
        mul_b = $signed(SMOOTH_K3 - MUL_B_W'({s, 1'b0}));
      end
      S_JMUL: begin
        mul_a = MUL_A_W'(delta);
        mul_b = $signed(MUL_B_W'(w));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wss_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      long_ticks  <= LONG_TICKS_RESET;
      short_ticks <= SHORT_TICKS_RESET;
      phase       <= PH_INIT;
      elapsed     <= '0;
      dur         <= '0;
      rem         <= '0;
      s           <= '0;
      w           <= '0;
      div_cnt     <= '0;
      jcnt        <= '0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        start_pose[j]   <= '0;
        current_pose[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LONG_TICKS:  long_ticks  <= cfg_data;
          REG_SHORT_TICKS: short_ticks <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!tick) begin
              state <= S_OUT;
            end else if (phase == PH_INIT) begin
              for (int j = 0; j < NUM_JOINTS; j++) begin
                current_pose[j] <= AW'(waypoint(PH_READY, JOINT_IDX_W'(j)));
                start_pose[j]   <= AW'(waypoint(PH_READY, JOINT_IDX_W'(j)));
              end
              elapsed <= '0;
              phase   <= PH_READY;
              state   <= S_OUT;
            end else begin
              elapsed <= elapsed_next;
              dur     <= dur_next;
              rem     <= elapsed_next;
              div_cnt <= '0;
              if (elapsed_next >= dur_next) begin
                s     <= S_ONE;
                state <= S_SQR;
              end else begin
                s     <= '0;
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          rem     <= rem_ge ? TW'(rem_sh - {1'b0, dur}) : rem_sh[TW-1:0];
          s       <= {s[S_W-2:0], rem_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          state <= S_CUBE;
        end
        S_CUBE: begin
          state <= S_WGT;
        end
        S_WGT: begin
          w     <= prod[48:32];
          jcnt  <= '0;
          state <= S_JMUL;
        end
        S_JMUL: begin
          state <= S_JACC;
        end
        S_JACC: begin
          current_pose[jcnt] <= start_pose[jcnt] + $signed(rounded[AW+FRAC_W-1:FRAC_W]);
          if (jcnt == LAST_JOINT) begin
            state <= S_END;
          end else begin
            jcnt  <= jcnt + JW'(1);
            state <= S_JMUL;
          end
        end
        S_END: begin
          if (elapsed >= dur) begin
            elapsed <= '0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
              start_pose[j] <= current_pose[j];
            end
            phase <= (phase == PH_RETURN) ? PH_READY : phase_t'(phase + 3'd1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < OUT_JOINTS; g++) begin : g_out
    if (g < NUM_JOINTS) begin : g_on
      assign out_pose[g] = current_pose[g];
    end else begin : g_off
      assign out_pose[g] = '0;
    end
  end

  assign base_angle        = out_pose[0];
  assign shoulder_angle    = out_pose[1];
  assign elbow_angle       = out_pose[2];
  assign wrist_pitch_angle = out_pose[3];
  assign wrist_roll_angle  = out_pose[4];
  assign gripper_left_pos  = out_pose[5];
  assign gripper_right_pos = out_pose[6];
  assign phase_out         = phase;

endmodule

// ===== hdl/wss_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing but its parameters.
module wss_mul #(
  parameter int A_W = 34,
  parameter int B_W = 19
) (
  input  logic                      clk,
  input  logic signed [A_W-1:0]     a,
  input  logic signed [B_W-1:0]     b,
  output logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for waypoint_smoothstep_sequencer: a local model of the
// phase sequence and smoothstep blend predicts every pose, and a checker compares each result.
// Depends on wss_pkg and the RTL of waypoint_smoothstep_sequencer.
module tb import wss_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    phase_t         ph;
    q14_t [6:0]     joint;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  q14_t base_angle, shoulder_angle, elbow_angle, wrist_pitch_angle, wrist_roll_angle;
  q14_t gripper_left_pos, gripper_right_pos;
  logic [2:0] phase_out;

  waypoint_smoothstep_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .tick(tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .base_angle(base_angle), .shoulder_angle(shoulder_angle), .elbow_angle(elbow_angle),
    .wrist_pitch_angle(wrist_pitch_angle), .wrist_roll_angle(wrist_roll_angle),
    .gripper_left_pos(gripper_left_pos), .gripper_right_pos(gripper_right_pos),
    .phase_out(phase_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  logic [7:0] long_ticks = LONG_TICKS_RESET;
  logic [7:0] short_ticks = SHORT_TICKS_RESET;
  phase_t model_phase = PH_INIT;
  logic [7:0] model_elapsed = '0;
  q14_t model_start [7] = '{default: '0};
  q14_t model_pose [7] = '{default: '0};

  pose_t pending_poses [$];
  int mismatches = 0;
  int random_sent = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  string joint_names [7] = '{"base_angle", "shoulder_angle", "elbow_angle",
                             "wrist_pitch_angle", "wrist_roll_angle",
                             "gripper_left_pos", "gripper_right_pos"};

  function automatic logic [7:0] phase_ticks(phase_t p);
    logic [7:0] d;
    d = (p == PH_GRASP || p == PH_RELEASE) ? short_ticks : long_ticks;
    if (d == 8'd0) begin
      d = 8'd1;
    end
    return d;
  endfunction

  function automatic longint unsigned smoothstep_weight(logic [7:0] e, logic [7:0] d);
    longint unsigned s;
    if (e > d) begin
      e = d;
    end
    s = (longint'(e) * 65536) / longint'(d);
    return (3 * s * s * 65536 - 2 * s * s * s) >> 32;
  endfunction

  function automatic q14_t blend_joint(q14_t a, q14_t b, longint unsigned w);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(w);
    return q14_t'(longint'(a) + ((prod + 64'sd32768) >>> 16));
  endfunction

  function automatic void advance_sequence(logic t);
    logic [7:0] d;
    longint unsigned w;
    pose_t p;
    if (t) begin
      if (model_phase == PH_INIT) begin
        for (int j = 0; j < 7; j++) begin
          model_pose[j] = WAYPOINT_ROM[PH_READY][j];
          model_start[j] = model_pose[j];
        end
        model_elapsed = '0;
        model_phase = PH_READY;
      end else begin
        d = phase_ticks(model_phase);
        if (model_elapsed != 8'hFF) begin
          model_elapsed = model_elapsed + 8'd1;
        end
        w = smoothstep_weight(model_elapsed, d);
        for (int j = 0; j < 7; j++) begin
          model_pose[j] = blend_joint(model_start[j], WAYPOINT_ROM[model_phase][j], w);
        end
        if (model_elapsed >= d) begin
          model_elapsed = '0;
          model_start = model_pose;
          model_phase = (model_phase == PH_RETURN) ? PH_READY : phase_t'(model_phase + 3'd1);
        end
      end
    end
    p.ph = model_phase;
    for (int j = 0; j < 7; j++) begin
      p.joint[j] = model_pose[j];
    end
    pending_poses.push_back(p);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!in_gaps_on || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input logic t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (in_stall);
    advance_sequence(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LONG_TICKS) begin
      long_ticks = v;
    end else begin
      short_ticks = v;
    end
    @(posedge clk);
  endtask

  task automatic test_before_start();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_first_tick();
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_default_durations();
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_zero_duration();
    wait_idle();
    write_reg(REG_LONG_TICKS, 8'd0);
    write_reg(REG_SHORT_TICKS, 8'd0);
    repeat (8) send_tick(1'b1);
  endtask

  task automatic test_short_durations();
    wait_idle();
    write_reg(REG_LONG_TICKS, 8'd2);
    write_reg(REG_SHORT_TICKS, 8'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_max_duration();
    wait_idle();
    write_reg(REG_LONG_TICKS, 8'd255);
    write_reg(REG_SHORT_TICKS, 8'd255);
    repeat (3) send_tick(1'b1);
  endtask

  function automatic logic [7:0] pick_ticks(input logic [7:0] reset_value);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 25) return 8'd255;
    if (r < 35) return 8'd1;
    if (r < 45) return reset_value;
    return 8'($urandom_range(1, 6));
  endfunction

  task automatic test_random_sequences();
    int n;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(REG_LONG_TICKS, pick_ticks(LONG_TICKS_RESET));
      write_reg(REG_SHORT_TICKS, pick_ticks(SHORT_TICKS_RESET));
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(10, 40);
      for (int i = 0; i < n; i++) begin
        send_tick($urandom_range(0, 9) < 8);
        random_sent++;
        if ($urandom_range(0, 49) == 0) begin
          wait_idle();
        end
      end
    end
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_start();
    test_first_tick();
    test_default_durations();
    test_zero_duration();
    test_short_durations();
    test_max_duration();
    test_random_sequences();
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("waypoint_smoothstep_sequencer: match");
    end else begin
      $display("waypoint_smoothstep_sequencer: mismatch");
    end
    $finish;
  end

  int stall_left = 0;

  always @(posedge clk) begin
    q14_t got [7];
    pose_t want;
    int r;
    if (!rst && out_valid && !out_stall) begin
      got = '{base_angle, shoulder_angle, elbow_angle, wrist_pitch_angle,
              wrist_roll_angle, gripper_left_pos, gripper_right_pos};
      if (pending_poses.size() == 0) begin
        $display("%0t: result with no item pending, phase_out %0d", $time, phase_out);
        mismatches++;
      end else begin
        want = pending_poses.pop_front();
        for (int j = 0; j < 7; j++) begin
          if (got[j] !== want.joint[j]) begin
            $display("%0t: %s expected %0d actual %0d", $time, joint_names[j],
                     $signed(want.joint[j]), $signed(got[j]));
            mismatches++;
          end
        end
        if (phase_out !== want.ph) begin
          $display("%0t: phase_out expected %0d actual %0d", $time, want.ph, phase_out);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (!out_gaps_on || r < 60) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(14, 39);
        out_stall <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("waypoint_smoothstep_sequencer: mismatch");
      $finish;
    end
  end

endmodule
